// File: rtl/wavhp_pkg.sv
// Shared types and default sizes for the WAV header parser.
// No dependencies; every other file of the block imports this package.
package wavhp_pkg;

	// Default window and search limit, in bytes
	localparam int WINDOW_BYTES_DEF  = 2048;
	localparam int SEARCH_MARGIN_DEF = 256;

	// Width of the data_begin result field
	localparam int BEGIN_W = 12;

	// One file byte with its framing marks
	typedef struct packed {
		logic [7:0] file_byte;
		logic       first_byte;
		logic       stream_end;
	} item_t;

	// One parse result
	typedef struct packed {
		logic               status;
		logic [1:0]         format_code;
		logic [31:0]        pcm_rate;
		logic [BEGIN_W-1:0] data_begin;
		logic [31:0]        data_end;
	} res_t;

endpackage

// File: rtl/wavhp_in_stage.sv
// Input register of the WAV header parser: holds one file byte item.
// Depends on wavhp_pkg for the item type.
module wavhp_in_stage import wavhp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	logic load;

	// Take a new item when empty or when the held one moves on this cycle
	assign in_ready = !valid_s1 || advance;
	assign load     = in_valid && in_ready;

	// Hold the item valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the payload
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

// File: rtl/wavhp_parse.sv
// Parse state and per-byte decision logic of the WAV header parser.
// Depends on wavhp_pkg for the item and result types.
module wavhp_parse import wavhp_pkg::*; #(
	parameter int WINDOW_BYTES  = WINDOW_BYTES_DEF,
	parameter int SEARCH_MARGIN = SEARCH_MARGIN_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  item_t item,
	output logic  has_result,
	output res_t  res
);

	localparam int          POS_W   = $clog2(WINDOW_BYTES + 4);
	localparam logic [33:0] WIN_L   = 34'(WINDOW_BYTES);
	localparam logic [33:0] LIMIT_L = 34'(WINDOW_BYTES - SEARCH_MARGIN);

	// Chunk and file signatures, first byte in the low bits
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_HEAD,
		PH_FMT_HDR,
		PH_FMT_SKIP,
		PH_FMT_BODY,
		PH_DATA_HDR,
		PH_DATA_SKIP,
		PH_DATA_SIZE,
		PH_DONE
	} phase_t;

	phase_t           phase_q, base_phase, nx_phase;
	logic [POS_W-1:0] pos_q, p;
	logic [POS_W-1:0] ncs_q, base_ncs, nx_ncs;
	logic [31:0]      shift_q, base_shift, sh;
	logic [15:0]      chan_q, base_chan, nx_chan;
	logic [15:0]      bits_q, base_bits, nx_bits;
	logic [31:0]      rate_q, base_rate, nx_rate;
	logic [31:0]      fsize_q, base_fsize, nx_fsize;
	logic [POS_W-1:0] off;
	logic             ge;
	logic [33:0]      ncs_ext, jump;
	logic             jump_fits;
	logic             active, err, acc;
	logic [31:0]      begin32;
	logic [7:0]       riff_b, wave_b;

	always_comb begin
		// Start from reset values on a new file
		base_phase = item.first_byte ? PH_HEAD : phase_q;
		base_ncs   = item.first_byte ? '0 : ncs_q;
		base_shift = item.first_byte ? '0 : shift_q;
		base_chan  = item.first_byte ? '0 : chan_q;
		base_bits  = item.first_byte ? '0 : bits_q;
		base_rate  = item.first_byte ? '0 : rate_q;
		base_fsize = item.first_byte ? '0 : fsize_q;
		active     = item.first_byte || (phase_q != PH_IDLE && phase_q != PH_DONE);
		p          = item.first_byte ? '0 : pos_q + 1'b1;
		sh         = {item.file_byte, base_shift[31:8]};
		off        = p - base_ncs;
		ge         = p >= base_ncs;
		ncs_ext    = 34'(base_ncs);
		riff_b     = TAG_RIFF[8*p[1:0] +: 8];
		wave_b     = TAG_WAVE[8*p[1:0] +: 8];

		// Start of the following chunk: after the fmt body or after a skipped chunk
		jump = ncs_ext + {2'b00, (base_phase == PH_FMT_BODY) ? base_fsize : sh} + 34'd8;
		jump_fits = (jump + 34'd4) <= WIN_L;

		nx_phase = base_phase;
		nx_ncs   = base_ncs;
		nx_chan  = base_chan;
		nx_bits  = base_bits;
		nx_rate  = base_rate;
		nx_fsize = base_fsize;
		err      = 1'b0;
		acc      = 1'b0;

		unique case (base_phase)
			PH_HEAD: begin
				// Check both signatures, then enter the chunk walk
				if (p < POS_W'(4) && item.file_byte != riff_b) begin
					err = 1'b1;
				end
				if (p >= POS_W'(8) && p < POS_W'(12) && item.file_byte != wave_b) begin
					err = 1'b1;
				end
				if (!err && p == POS_W'(11)) begin
					nx_ncs   = POS_W'(12);
					nx_phase = PH_FMT_HDR;
				end
			end
			PH_FMT_HDR, PH_DATA_HDR: begin
				// Decide on the chunk id once its last byte is in
				if (ge && off == POS_W'(3)) begin
					if (base_phase == PH_FMT_HDR && sh == TAG_FMT) begin
						if (ncs_ext + 34'd24 > WIN_L) err = 1'b1;
						else nx_phase = PH_FMT_BODY;
					end else if (base_phase == PH_DATA_HDR && sh == TAG_DATA) begin
						if (ncs_ext + 34'd8 > WIN_L) err = 1'b1;
						else nx_phase = PH_DATA_SIZE;
					end else if (ncs_ext > LIMIT_L) begin
						err = 1'b1;
					end else begin
						nx_phase = (base_phase == PH_FMT_HDR) ? PH_FMT_SKIP : PH_DATA_SKIP;
					end
				end
			end
			PH_FMT_SKIP, PH_DATA_SKIP: begin
				// Jump over the chunk body once its size is in
				if (off == POS_W'(7)) begin
					if (!jump_fits) begin
						err = 1'b1;
					end else begin
						nx_ncs   = jump[POS_W-1:0];
						nx_phase = (base_phase == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
					end
				end
			end
			PH_FMT_BODY: begin
				// Check and keep the format fields
				if (off == POS_W'(7)) begin
					nx_fsize = sh;
					if (sh < 32'd16) err = 1'b1;
				end else if (off == POS_W'(9)) begin
					if (sh[31:16] != 16'd1) err = 1'b1;
				end else if (off == POS_W'(11)) begin
					nx_chan = sh[31:16];
					if (sh[31:16] > 16'd2) err = 1'b1;
				end else if (off == POS_W'(15)) begin
					nx_rate = sh;
				end else if (off == POS_W'(23)) begin
					nx_bits = sh[31:16];
					if (sh[31:16] != 16'd16 && sh[31:16] != 16'd24) begin
						err = 1'b1;
					end else if (!jump_fits) begin
						err = 1'b1;
					end else begin
						nx_ncs   = jump[POS_W-1:0];
						nx_phase = PH_DATA_HDR;
					end
				end
			end
			PH_DATA_SIZE: begin
				if (off == POS_W'(7)) acc = 1'b1;
			end
			default: begin
			end
		endcase

		// Early end of the stream
		if (!err && !acc && item.stream_end) err = 1'b1;
		if (err || acc) nx_phase = PH_DONE;

		has_result = active && (err || acc);

		// Build the result item
		begin32 = 32'(base_ncs) + 32'd8;
		if (acc) begin
			res.status      = 1'b0;
			res.format_code = {base_chan != 16'd2, base_bits == 16'd24};
			res.pcm_rate    = base_rate;
			res.data_begin  = begin32[BEGIN_W-1:0];
			res.data_end    = begin32 + sh;
		end else begin
			res.status      = 1'b1;
			res.format_code = '0;
			res.pcm_rate    = '0;
			res.data_begin  = '0;
			res.data_end    = '0;
		end
	end

	// Hold the parse state; advance it on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			ncs_q   <= '0;
			shift_q <= '0;
			chan_q  <= '0;
			bits_q  <= '0;
			rate_q  <= '0;
			fsize_q <= '0;
		end else if (step && active) begin
			phase_q <= nx_phase;
			pos_q   <= p;
			ncs_q   <= nx_ncs;
			shift_q <= sh;
			chan_q  <= nx_chan;
			bits_q  <= nx_bits;
			rate_q  <= nx_rate;
			fsize_q <= nx_fsize;
		end
	end

endmodule

// File: rtl/wavhp_out_reg.sv
// Result register of the WAV header parser: holds one result item.
// Depends on wavhp_pkg for the result type.
module wavhp_out_reg import wavhp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	output logic out_valid,
	input  logic out_ready,
	output res_t res_q
);

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// File: rtl/wav_header_parser_unit.sv
// WAV header parser: takes a file one byte per item and gives at most one result
// per file (header accepted with format, rate and data span, or an error). It
// accepts one byte every cycle while not stalled; each result passes through the input
// register, then the result register. It stalls only while the result register holds
// an item not yet taken. Depends on wavhp_pkg.
module wav_header_parser_unit import wavhp_pkg::*; #(
	parameter int WINDOW_BYTES  = WINDOW_BYTES_DEF,
	parameter int SEARCH_MARGIN = SEARCH_MARGIN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         file_byte,
	input  logic               first_byte,
	input  logic               stream_end,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               status,
	output logic [1:0]         format_code,
	output logic [31:0]        pcm_rate,
	output logic [BEGIN_W-1:0] data_begin,
	output logic [31:0]        data_end
);

	item_t in_item, item_s1;
	logic  valid_s1, advance, has_result;
	res_t  res_c, res_q;

	assign in_item = '{file_byte: file_byte, first_byte: first_byte, stream_end: stream_end};

	// Move the held item through when the result slot is free or being emptied
	assign advance = valid_s1 && (!out_valid || out_ready);

	wavhp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	wavhp_parse #(
		.WINDOW_BYTES  (WINDOW_BYTES),
		.SEARCH_MARGIN (SEARCH_MARGIN)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item       (item_s1),
		.has_result (has_result),
		.res        (res_c)
	);

	wavhp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && has_result),
		.res_in    (res_c),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign status      = res_q.status;
	assign format_code = res_q.format_code;
	assign pcm_rate    = res_q.pcm_rate;
	assign data_begin  = res_q.data_begin;
	assign data_end    = res_q.data_end;

endmodule

// File: test/tb_wav_header_parser_unit.sv
// Testbench for wav_header_parser_unit: streams WAV files byte by byte and checks
// every parse result against a built-in model of the header walk.
// Depends on wavhp_pkg and the wav_header_parser_unit RTL.
`timescale 1ns / 100ps

module tb_wav_header_parser_unit;
	import wavhp_pkg::*;

	localparam int WIN          = WINDOW_BYTES_DEF;
	localparam int MARGIN       = SEARCH_MARGIN_DEF;
	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam int ALL_BYTES    = 1 << 20;
	localparam int MAX_PRINTS   = 20;

	// Chunk ids as little-endian words
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;
	localparam logic [31:0] TAG_JUNK = 32'h4b4e_554a;
	localparam logic [15:0] FMT_PCM  = 16'd1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_HEAD, ST_FMT_HDR, ST_FMT_SKIP, ST_FMT_BODY,
		ST_DATA_HDR, ST_DATA_SKIP, ST_DATA_SIZE, ST_DONE
	} parse_state_t;

	typedef enum logic [1:0] {V_NONE, V_ERR, V_OK} verdict_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         file_byte;
	logic               first_byte;
	logic               stream_end;
	logic               out_valid;
	logic               out_ready;
	logic               status;
	logic [1:0]         format_code;
	logic [31:0]        pcm_rate;
	logic [BEGIN_W-1:0] data_begin;
	logic [31:0]        data_end;

	// Model state of the header walk
	parse_state_t m_state = ST_IDLE;
	int unsigned  m_pos = 0;
	logic [32:0]  m_chunk = '0;
	logic [31:0]  m_shift = '0;
	logic [15:0]  m_chans = '0;
	logic [15:0]  m_depth = '0;
	logic [31:0]  m_rate = '0;
	logic [31:0]  m_fmt_len = '0;

	res_t       expected_headers[$];
	logic [7:0] file_bytes[$];
	res_t       want;

	int errors = 0;
	int bytes_sent = 0;
	int bytes_parsed = 0;
	int files_sent = 0;
	int results_predicted = 0;
	int headers_checked = 0;
	int headers_accepted = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;

	wav_header_parser_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.file_byte  (file_byte),
		.first_byte (first_byte),
		.stream_end (stream_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.format_code(format_code),
		.pcm_rate   (pcm_rate),
		.data_begin (data_begin),
		.data_end   (data_end)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the model by one accepted byte; queue the header result it decides
	function void predict_byte(input logic [7:0] b, input logic f, input logic e);
		verdict_t    v;
		int unsigned off;
		logic [32:0] cand;
		logic [31:0] begin_at;
		res_t        r;
		v = V_NONE;
		off = 0;
		if (f) begin
			m_state = ST_HEAD;
			m_pos = 0;
			m_chunk = '0;
			m_shift = '0;
			m_chans = '0;
			m_depth = '0;
			m_rate = '0;
			m_fmt_len = '0;
		end else begin
			if (m_state == ST_IDLE || m_state == ST_DONE)
				return;
			m_pos++;
		end
		bytes_parsed++;
		m_shift = {b, m_shift[31:8]};
		if (m_state != ST_HEAD && {1'b0, m_pos} >= m_chunk)
			off = m_pos - m_chunk[31:0];

		case (m_state)
			ST_HEAD: begin
				if (m_pos < 4 && b != TAG_RIFF[8*m_pos[1:0] +: 8])
					v = V_ERR;
				if (m_pos >= 8 && m_pos < 12 && b != TAG_WAVE[8*m_pos[1:0] +: 8])
					v = V_ERR;
				if (v == V_NONE && m_pos == 11) begin
					m_chunk = 33'd12;
					m_state = ST_FMT_HDR;
				end
			end
			ST_FMT_HDR, ST_DATA_HDR: begin
				// Decide on the chunk id once its last byte is in
				if ({1'b0, m_pos} >= m_chunk && off == 3) begin
					if (m_state == ST_FMT_HDR && m_shift == TAG_FMT) begin
						if (m_chunk + 24 > WIN) v = V_ERR;
						else m_state = ST_FMT_BODY;
					end else if (m_state == ST_DATA_HDR && m_shift == TAG_DATA) begin
						if (m_chunk + 8 > WIN) v = V_ERR;
						else m_state = ST_DATA_SIZE;
					end else if (m_chunk > WIN - MARGIN) begin
						v = V_ERR;
					end else begin
						m_state = (m_state == ST_FMT_HDR) ? ST_FMT_SKIP : ST_DATA_SKIP;
					end
				end
			end
			ST_FMT_SKIP, ST_DATA_SKIP: begin
				// Jump over the chunk body, no pad byte
				if (off == 7) begin
					cand = m_chunk + {1'b0, m_shift} + 33'd8;
					if (cand + 4 > WIN) begin
						v = V_ERR;
					end else begin
						m_chunk = cand;
						m_state = (m_state == ST_FMT_SKIP) ? ST_FMT_HDR : ST_DATA_HDR;
					end
				end
			end
			ST_FMT_BODY: begin
				if (off == 7) begin
					m_fmt_len = m_shift;
					if (m_fmt_len < 16) v = V_ERR;
				end else if (off == 9) begin
					if (m_shift[31:16] != FMT_PCM) v = V_ERR;
				end else if (off == 11) begin
					m_chans = m_shift[31:16];
					if (m_chans > 2) v = V_ERR;
				end else if (off == 15) begin
					m_rate = m_shift;
				end else if (off == 23) begin
					m_depth = m_shift[31:16];
					if (m_depth != 16 && m_depth != 24) begin
						v = V_ERR;
					end else begin
						cand = m_chunk + {1'b0, m_fmt_len} + 33'd8;
						if (cand + 4 > WIN) begin
							v = V_ERR;
						end else begin
							m_chunk = cand;
							m_state = ST_DATA_HDR;
						end
					end
				end
			end
			ST_DATA_SIZE: begin
				if (off == 7) v = V_OK;
			end
			default: ;
		endcase

		if (v == V_NONE && e)
			v = V_ERR;
		if (v == V_NONE)
			return;

		r = '0;
		r.status = 1'b1;
		if (v == V_OK) begin
			begin_at = m_chunk[31:0] + 32'd8;
			r.status = 1'b0;
			r.format_code = {(m_chans != 16'd2), (m_depth == 16'd24)};
			r.pcm_rate = m_rate;
			r.data_begin = begin_at[BEGIN_W-1:0];
			r.data_end = begin_at + m_shift;
		end
		m_state = ST_DONE;
		expected_headers.push_back(r);
		results_predicted++;
	endfunction

	// File image builders
	function void add16(input logic [15:0] v);
		file_bytes.push_back(v[7:0]);
		file_bytes.push_back(v[15:8]);
	endfunction

	function void add32(input logic [31:0] v);
		add16(v[15:0]);
		add16(v[31:16]);
	endfunction

	function void add_fill(input int n);
		repeat (n) file_bytes.push_back(8'($urandom));
	endfunction

	function void add_junk(input int size);
		add32($urandom_range(1) ? TAG_JUNK : $urandom);
		add32(size);
		add_fill(size);
	endfunction

	// RIFF/WAVE head, optional chunk, fmt, optional chunk, data head and a few samples
	function void make_wav(input logic [15:0] fmt_tag, input logic [15:0] chans,
			input logic [15:0] depth, input logic [31:0] rate, input logic [31:0] fmt_len,
			input logic [31:0] data_len, input int pre_size, input int post_size);
		file_bytes.delete();
		add32(TAG_RIFF);
		add32($urandom);
		add32(TAG_WAVE);
		if (pre_size >= 0) add_junk(pre_size);
		add32(TAG_FMT);
		add32(fmt_len);
		add16(fmt_tag);
		add16(chans);
		add32(rate);
		add32($urandom);
		add16(16'($urandom));
		add16(depth);
		if (fmt_len > 16 && fmt_len <= 64) add_fill(fmt_len - 16);
		if (post_size >= 0) add_junk(post_size);
		add32(TAG_DATA);
		add32(data_len);
		add_fill(4);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, exp_val);
	endtask

	// Offer one byte, with random idle cycles ahead of it; return at the accepting edge
	task automatic send_byte(input logic [7:0] b, input logic f, input logic e);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		file_byte <= b;
		first_byte <= f;
		stream_end <= e;
		do @(posedge clk); while (!in_ready);
		predict_byte(b, f, e);
		bytes_sent++;
	endtask

	task automatic send_file(input int count, input bit mark_end);
		int n;
		n = (count < file_bytes.size()) ? count : file_bytes.size();
		for (int i = 0; i < n; i++)
			send_byte(file_bytes[i], i == 0, mark_end && i == n - 1);
		files_sent++;
	endtask

	// Hold the input until every queued header result is back
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		while (expected_headers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic test_good_headers();
		make_wav(FMT_PCM, 16'd2, 16'd16, 32'd44100, 32'd16, 32'd1000, -1, -1);
		send_file(ALL_BYTES, 1'b1);
		make_wav(FMT_PCM, 16'd1, 16'd24, 32'd96000, 32'd18, 32'h0000_1234, 2, 0);
		send_file(ALL_BYTES, 1'b1);
		// zero channels reads as mono; data end wraps past 2^32
		make_wav(FMT_PCM, 16'd0, 16'd16, 32'hFFFF_FFFF, 32'd16, 32'hFFFF_FFFF, -1, -1);
		send_file(ALL_BYTES, 1'b1);
	endtask

	task automatic test_bad_signatures();
		make_wav(FMT_PCM, 16'd2, 16'd16, 32'd48000, 32'd16, 32'd64, -1, -1);
		file_bytes[0] = 8'h00;
		send_file(4, 1'b1);
		make_wav(FMT_PCM, 16'd2, 16'd16, 32'd48000, 32'd16, 32'd64, -1, -1);
		file_bytes[11] = 8'hFF;
		send_file(12, 1'b1);
	endtask

	// Each file is cut just after the byte that should fail it
	task automatic test_fmt_checks();
		make_wav(16'd3, 16'd2, 16'd16, 32'd44100, 32'd16, 32'd8, -1, -1);
		send_file(22, 1'b1);
		make_wav(FMT_PCM, 16'd3, 16'd16, 32'd44100, 32'd16, 32'd8, -1, -1);
		send_file(24, 1'b1);
		make_wav(FMT_PCM, 16'd2, 16'd8, 32'd44100, 32'd16, 32'd8, -1, -1);
		send_file(36, 1'b1);
		make_wav(FMT_PCM, 16'd2, 16'd16, 32'd44100, 32'd15, 32'd8, -1, -1);
		send_file(20, 1'b1);
		// fmt size that throws the next chunk out of the window
		make_wav(FMT_PCM, 16'd1, 16'd24, 32'd22050, 32'hFFFF_FFF0, 32'd8, -1, -1);
		send_file(36, 1'b1);
	endtask

	task automatic test_stream_framing();
		// bytes with no file open are dropped
		send_byte(8'h00, 1'b0, 1'b1);
		send_byte(8'hFF, 1'b0, 1'b0);
		// end of stream inside the header
		make_wav(FMT_PCM, 16'd2, 16'd16, 32'd44100, 32'd16, 32'd100, -1, -1);
		send_file(20, 1'b1);
		// a lone first byte that is also the last
		send_byte(TAG_RIFF[7:0], 1'b1, 1'b1);
		// end of stream on the byte that completes the data size
		make_wav(FMT_PCM, 16'd1, 16'd16, 32'd11025, 32'd16, 32'd77, -1, -1);
		send_file(44, 1'b1);
		// restart a file in the middle of its fmt chunk header
		make_wav(FMT_PCM, 16'd2, 16'd24, 32'd88200, 32'd16, 32'd5, -1, -1);
		send_file(14, 1'b0);
		make_wav(FMT_PCM, 16'd2, 16'd24, 32'd88200, 32'd16, 32'd5, -1, -1);
		send_file(ALL_BYTES, 1'b1);
	endtask

	task automatic test_window_limits();
		// chunk size that puts the next id past the window
		file_bytes.delete();
		add32(TAG_RIFF);
		add32(32'd0);
		add32(TAG_WAVE);
		add32(TAG_JUNK);
		add32(32'hFFFF_FFF0);
		add_fill(8);
		send_file(ALL_BYTES, 1'b1);
	endtask

	// Mostly well-formed files with random fields; some corrupted, cut short or noisy
	task automatic test_random_files(input int want_results, input int want_bytes);
		int          res0;
		int          bytes0;
		int          r;
		int          count;
		int          pre;
		int          post;
		bit          mark;
		logic [15:0] chans;
		logic [15:0] depth;
		logic [15:0] ftag;
		logic [31:0] flen;
		res0 = results_predicted;
		bytes0 = bytes_parsed;
		while (results_predicted - res0 < want_results || bytes_parsed - bytes0 < want_bytes) begin
			r = $urandom_range(9);
			chans = (r < 4) ? 16'd1 : (r < 8) ? 16'd2 : (r == 8) ? 16'd0 :
				16'($urandom_range(65535, 3));
			depth = ($urandom_range(9) == 0) ? 16'($urandom) :
				($urandom_range(1) ? 16'd24 : 16'd16);
			ftag = ($urandom_range(9) == 0) ? 16'($urandom) : FMT_PCM;
			r = $urandom_range(19);
			flen = (r < 14) ? 32'd16 : (r < 18) ? 32'(16 + $urandom_range(8, 1)) :
				(r == 18) ? 32'($urandom_range(15)) : $urandom;
			pre = ($urandom_range(4) < 3) ? -1 : int'($urandom_range(40));
			post = ($urandom_range(4) < 3) ? -1 : int'($urandom_range(40));
			make_wav(ftag, chans, depth, $urandom, flen, $urandom, pre, post);
			if ($urandom_range(9) == 0)
				file_bytes[$urandom_range(file_bytes.size() - 1)] = 8'($urandom);
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0, 1'($urandom));
			r = $urandom_range(9);
			count = (r < 8) ? file_bytes.size() : int'($urandom_range(file_bytes.size(), 1));
			mark = (r != 9);
			send_file(count, mark);
		end
	endtask

	// Hold the output for a long stretch while one-byte bad files keep coming
	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (12) send_byte(8'h5A, 1'b1, 1'b0);
		files_sent += 12;
	endtask

	// Output side: random stalls, or one long hold when asked
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Compare each taken result with the oldest expected header
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_headers.size() == 0) begin
				report_mismatch("result with none expected, status", 32'(status), 32'd0);
			end else begin
				want = expected_headers.pop_front();
				headers_checked++;
				if (want.status == 1'b0) headers_accepted++;
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (format_code !== want.format_code)
					report_mismatch("format_code", 32'(format_code), 32'(want.format_code));
				if (pcm_rate !== want.pcm_rate)
					report_mismatch("pcm_rate", pcm_rate, want.pcm_rate);
				if (data_begin !== want.data_begin)
					report_mismatch("data_begin", 32'(data_begin), 32'(want.data_begin));
				if (data_end !== want.data_end)
					report_mismatch("data_end", data_end, want.data_end);
			end
		end
	end

	// Stop a hung run: count cycles in which no item moves on either side
	initial begin
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("no progress for %0d cycles, %0d results outstanding",
			STALL_LIMIT, expected_headers.size());
		$display("FAIL wav_header_parser_unit");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		file_byte <= 8'h00;
		first_byte <= 1'b0;
		stream_end <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(0, 0);
		test_good_headers();
		test_bad_signatures();
		pause_until_drained();

		set_idling(69, 0);
		test_fmt_checks();
		pause_until_drained();

		set_idling(0, 69);
		test_stream_framing();
		pause_until_drained();

		set_idling(28, 28);
		test_window_limits();
		test_random_files(2, 48);
		pause_until_drained();

		set_idling(0, 0);
		test_backpressure();
		pause_until_drained();

		if (expected_headers.size() != 0)
			report_mismatch("results never returned", 32'(expected_headers.size()), 32'd0);
		$display("Streamed %0d files, %0d bytes (%0d parsed); %0d results checked, %0d accepted.",
			files_sent, bytes_sent, bytes_parsed, headers_checked, headers_accepted);
		$display("Covered signature, fmt, framing, window overflow and random files, four idle mixes, long stall.");
		if (errors == 0) begin
			$display("PASS wav_header_parser_unit");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAIL wav_header_parser_unit");
		end
		$finish;
	end

endmodule
